[sv/rgb_gamma_lut_interpolator_top_defines.svh]
// Assertion macros shared by the gamma stage RTL.
// No dependencies; the modules that assert pull this in by `include.
`ifndef RGB_GAMMA_LUT_INTERPOLATOR_TOP_DEFINES_SVH
`define RGB_GAMMA_LUT_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define RGBG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define RGBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/rgbg_pkg.sv]
// Shared constants and control structs for the RGB gamma stage.
// No dependencies.
package rgbg_pkg;

    localparam int TABLE_ENTRIES_DFLT = 257;

    localparam int SAMPLE_W  = 16;
    localparam int TBL_W     = 14;
    localparam int OUT_W     = 10;
    localparam int IDX_W     = 9;
    localparam int FRAC_W    = 6;
    localparam int K_W       = 8;
    localparam int S14_SHIFT = SAMPLE_W - TBL_W;   // 2
    localparam int BYP_SHIFT = SAMPLE_W - OUT_W;   // 6
    localparam int OUT_SHIFT = TBL_W - OUT_W;      // 4
    localparam int ROUND     = 32;
    localparam int TBL_MAX   = 16383;

    // signed difference, product and sum widths
    localparam int DIFF_W = TBL_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int Y_W    = TBL_W + 3;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [TBL_W-1:0]    data;
    } t_tbl_wr;

    typedef struct packed {
        logic rd_en;    // pixel accepted: read table, load stage 1
        logic s2_en;    // stage 1 -> stage 2
        logic out_en;   // stage 2 -> output register
        logic bypass;
    } t_pipe_ctl;

endpackage

[sv/rgb_gamma_lut_interpolator_top.sv]
// Top level of the RGB gamma stage: handshakes, pipeline control, bypass
// register and three channel lanes. Depends on rgbg_pkg, rgbg_bank, rgbg_interp.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+----------------------------------
//   request   | i_valid / o_stall          | i_cmd, i_*_in, i_entry_index/value
//   result    | o_valid / i_stall          | o_red_out, o_green_out, o_blue_out
//   config    | i_cfg_wr_en (no handshake) | i_cfg_wr_data (bypass)
//
// One request per cycle while o_stall is low. A pixel passes the table read,
// the multiply, then floor/add/clamp to the output register. A table write
// completes at its accept edge, makes no result, and is read by a pixel right
// behind it. Table contents are not reset; reading an entry never written is
// undefined. A stalled result holds; the two inner stages keep filling, so up
// to three pixels are in flight before o_stall rises.
module rgb_gamma_lut_interpolator_top import rgbg_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_cmd,
    input  logic [SAMPLE_W-1:0] i_red_in,
    input  logic [SAMPLE_W-1:0] i_green_in,
    input  logic [SAMPLE_W-1:0] i_blue_in,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [TBL_W-1:0]    i_entry_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [OUT_W-1:0]    o_red_out,
    output logic [OUT_W-1:0]    o_green_out,
    output logic [OUT_W-1:0]    o_blue_out
);

    `include "rgb_gamma_lut_interpolator_top_defines.svh"

    logic r_bypass;
    logic r_s1_v, r_s2_v, r_out_v;
    logic n_s1_v, n_s2_v, n_out_v;

    logic      out_free, s2_free, s1_free, accept;
    t_pipe_ctl ctl;
    t_tbl_wr   wr;

    logic [SAMPLE_W-1:0] sample [3];
    logic [OUT_W-1:0]    code   [3];

    // stall ripples back from the output register
    always_comb begin
        out_free = !r_out_v || !i_stall;
        s2_free  = !r_s2_v || out_free;
        s1_free  = !r_s1_v || s2_free;
        accept   = i_valid && s1_free;

        ctl.rd_en  = accept && !i_cmd;
        ctl.s2_en  = r_s1_v && s2_free;
        ctl.out_en = r_s2_v && out_free;
        ctl.bypass = r_bypass;

        wr.en   = accept && i_cmd;
        wr.idx  = i_entry_index;
        wr.data = i_entry_value;

        n_s1_v  = s1_free  ? (accept && !i_cmd) : r_s1_v;
        n_s2_v  = s2_free  ? r_s1_v : r_s2_v;
        n_out_v = out_free ? r_s2_v : r_out_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bypass <= i_cfg_wr_data;
            end
            r_s1_v  <= n_s1_v;
            r_s2_v  <= n_s2_v;
            r_out_v <= n_out_v;
        end
    end

    assign sample[0] = i_red_in;
    assign sample[1] = i_green_in;
    assign sample[2] = i_blue_in;

    // each lane owns a table copy so all six reads happen in the same cycle
    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic [TBL_W-1:0] rd_even;
        logic [TBL_W-1:0] rd_odd;

        rgbg_bank #(
            .TABLE_ENTRIES (TABLE_ENTRIES)
        ) u_bank (
            .i_clk   (i_clk),
            .i_wr    (wr),
            .i_rd_en (ctl.rd_en),
            .i_k     (sample[c][SAMPLE_W-1 -: K_W]),
            .o_even  (rd_even),
            .o_odd   (rd_odd)
        );

        rgbg_interp u_interp (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_sample (sample[c]),
            .i_even   (rd_even),
            .i_odd    (rd_odd),
            .o_code   (code[c])
        );
    end

    assign o_stall     = !s1_free;
    assign o_valid     = r_out_v;
    assign o_red_out   = code[0];
    assign o_green_out = code[1];
    assign o_blue_out  = code[2];

    // table writes never occupy a pipeline slot
    `RGBG_ASSERT_NEXT(a_cmd_no_slot, i_valid && !o_stall && i_cmd, !r_s1_v, "table write entered pipeline")
    // an empty front stage always takes a request
    `RGBG_ASSERT_NOW(a_empty_ready, !r_s1_v, !o_stall, "stall raised with empty stage 1")
    // a blocked stage 2 keeps its pixel
    `RGBG_ASSERT_NEXT(a_s2_hold, r_s2_v && r_out_v && i_stall, r_s2_v, "stage 2 pixel dropped")
    // stall only when every stage is full and the output is blocked
    `RGBG_ASSERT_NOW(a_stall_full, o_stall, r_s1_v && r_s2_v && r_out_v && i_stall, "spurious stall")

endmodule

[sv/rgbg_bank.sv]
// One channel's copy of the gamma table, split into even and odd entry banks.
// Depends on rgbg_pkg. Every channel holds its own copy; writes go to all.
module rgbg_bank import rgbg_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DFLT
) (
    input  logic               i_clk,
    input  t_tbl_wr            i_wr,
    input  logic               i_rd_en,
    input  logic [K_W-1:0]     i_k,
    output logic [TBL_W-1:0]   o_even,
    output logic [TBL_W-1:0]   o_odd
);

    localparam int EVEN_DEPTH = (TABLE_ENTRIES + 1) / 2;
    localparam int ODD_DEPTH  = TABLE_ENTRIES / 2;
    localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
    localparam int ODD_AW     = $clog2(ODD_DEPTH);

    logic [TBL_W-1:0] mem_even [EVEN_DEPTH];
    logic [TBL_W-1:0] mem_odd  [ODD_DEPTH];

    logic [EVEN_AW-1:0] rd_even_addr;
    logic [ODD_AW-1:0]  rd_odd_addr;
    logic [EVEN_AW-1:0] wr_even_addr;
    logic [ODD_AW-1:0]  wr_odd_addr;
    logic               wr_ok;

    // entries k and k+1 always sit in opposite banks
    assign rd_odd_addr  = ODD_AW'(i_k[K_W-1:1]);
    assign rd_even_addr = EVEN_AW'(i_k[K_W-1:1]) + EVEN_AW'(i_k[0]);

    assign wr_ok        = i_wr.en && (i_wr.idx < IDX_W'(TABLE_ENTRIES));
    assign wr_even_addr = EVEN_AW'(i_wr.idx[IDX_W-1:1]);
    assign wr_odd_addr  = ODD_AW'(i_wr.idx[IDX_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (wr_ok && !i_wr.idx[0]) begin
            mem_even[wr_even_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            o_even <= mem_even[rd_even_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok && i_wr.idx[0]) begin
            mem_odd[wr_odd_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            o_odd <= mem_odd[rd_odd_addr];
        end
    end

endmodule

[sv/rgbg_interp.sv]
// Interpolation datapath for one channel: difference times fraction, then
// floor shift, add, clamp and cut to a 10-bit code. Depends on rgbg_pkg.
module rgbg_interp import rgbg_pkg::*; (
    input  logic                i_clk,
    input  t_pipe_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [TBL_W-1:0]    i_even,
    input  logic [TBL_W-1:0]    i_odd,
    output logic [OUT_W-1:0]    o_code
);

    // stage 1, alongside the table read data
    logic              r_par;
    logic [FRAC_W-1:0] r_frac;
    logic [OUT_W-1:0]  r_hi;
    // stage 2
    logic signed [PROD_W-1:0] r_prod;
    logic [TBL_W-1:0]         r_t0;
    logic [OUT_W-1:0]         r_hi2;

    logic [TBL_W-1:0]         t0;
    logic [TBL_W-1:0]         t1;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [Y_W-1:0]    y;
    logic [TBL_W-1:0]         y_clamp;
    logic [OUT_W-1:0]         n_code;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_par  <= i_sample[S14_SHIFT+FRAC_W];
            r_frac <= i_sample[S14_SHIFT +: FRAC_W];
            r_hi   <= i_sample[BYP_SHIFT +: OUT_W];
        end
    end

    always_comb begin
        t0     = r_par ? i_odd  : i_even;
        t1     = r_par ? i_even : i_odd;
        diff   = $signed({1'b0, t1}) - $signed({1'b0, t0});
        n_prod = PROD_W'(diff) * PROD_W'($signed({1'b0, r_frac})) + PROD_W'(ROUND);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_en) begin
            r_prod <= n_prod;
            r_t0   <= t0;
            r_hi2  <= r_hi;
        end
    end

    // arithmetic shift floors negative products
    always_comb begin
        y = Y_W'($signed({1'b0, r_t0})) + Y_W'(r_prod >>> FRAC_W);
        if (y < 0) begin
            y_clamp = '0;
        end else if (y > Y_W'(TBL_MAX)) begin
            y_clamp = TBL_W'(TBL_MAX);
        end else begin
            y_clamp = y[TBL_W-1:0];
        end
        n_code = i_ctl.bypass ? r_hi2 : y_clamp[OUT_SHIFT +: OUT_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_en) begin
            o_code <= n_code;
        end
    end

endmodule

[tb/sv/rgbg_tb_pkg.sv]
`timescale 1ns / 100ps
// Request codes and the per-pixel result record shared by the gamma stage testbench.
// Depends on rgbg_pkg for the channel widths.
package rgbg_tb_pkg;

    import rgbg_pkg::*;

    typedef enum logic {
        CMD_PIXEL    = 1'b0,
        CMD_TABLE_WR = 1'b1
    } t_req_cmd;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb_code;

endpackage

[tb/sv/rgb_gamma_checker.sv]
`timescale 1ns / 100ps
// Gamma stage checker: follows bypass writes and table loads, predicts the
// 10-bit codes of each accepted pixel and compares them in order. Uses rgbg_pkg, rgbg_tb_pkg.
module rgb_gamma_checker import rgbg_pkg::*, rgbg_tb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic                i_req_cmd,
    input  logic [SAMPLE_W-1:0] i_red_in,
    input  logic [SAMPLE_W-1:0] i_green_in,
    input  logic [SAMPLE_W-1:0] i_blue_in,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [TBL_W-1:0]    i_entry_value,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  logic [OUT_W-1:0]    i_red_out,
    input  logic [OUT_W-1:0]    i_green_out,
    input  logic [OUT_W-1:0]    i_blue_out,
    output int                  o_mismatches,
    output int                  o_pending
);

    logic [TBL_W-1:0] curve [0:TABLE_ENTRIES_DFLT-1];
    logic             bypass_q = 1'b0;
    t_rgb_code        pending_codes [$];
    int               mismatch_cnt = 0;
    int               pending_n = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_n;

    // floor interpolation between the two entries, clamp, keep the top 10 bits
    function automatic logic [OUT_W-1:0] gamma_code(input logic [SAMPLE_W-1:0] sample);
        logic [TBL_W-1:0] s14;
        int seg;
        int frac;
        int lo;
        int hi;
        int y;
        s14  = TBL_W'(sample >> S14_SHIFT);
        seg  = int'(s14 >> FRAC_W);
        frac = int'(s14[FRAC_W-1:0]);
        if (bypass_q) begin
            gamma_code = OUT_W'(sample >> BYP_SHIFT);
        end else begin
            lo = int'(curve[seg]);
            hi = int'(curve[seg + 1]);
            y  = lo + (((hi - lo) * frac + ROUND) >>> FRAC_W);
            if (y < 0) y = 0;
            if (y > TBL_MAX) y = TBL_MAX;
            gamma_code = OUT_W'(y >> OUT_SHIFT);
        end
    endfunction

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rgb_code want;
        if (i_rst_n) begin
            if (i_cfg_wr_en) bypass_q = i_cfg_wr_data;
            // results first, so a stray result never pairs with this edge's pixel
            if (i_res_valid && !i_res_stall) begin
                if (pending_codes.size() == 0) begin
                    $display("%0t: result with none expected, got %0d %0d %0d",
                             $time, i_red_out, i_green_out, i_blue_out);
                    mismatch_cnt++;
                end else begin
                    want = pending_codes.pop_front();
                    check_field("red_out", want.red, i_red_out);
                    check_field("green_out", want.green, i_green_out);
                    check_field("blue_out", want.blue, i_blue_out);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_req_cmd == CMD_TABLE_WR) begin
                    if (i_entry_index < TABLE_ENTRIES_DFLT)
                        curve[i_entry_index] = i_entry_value;
                end else begin
                    want.red   = gamma_code(i_red_in);
                    want.green = gamma_code(i_green_in);
                    want.blue  = gamma_code(i_blue_in);
                    pending_codes = {pending_codes, want};
                end
            end
        end
        pending_n <= pending_codes.size();
    end

endmodule

[tb/sv/rgb_gamma_lut_interpolator_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the RGB gamma stage: clock, reset, request and result
// drivers, bypass writes and the verdict. Uses rgbg_pkg, rgbg_tb_pkg, rgb_gamma_checker.
module rgb_gamma_lut_interpolator_top_tb;

    import rgbg_pkg::*;
    import rgbg_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_REQS   = 110;     // counted requests per random phase
    localparam int NUM_PHASES   = 5;
    localparam int DRAIN_CYCLES = 8;       // pipeline is three deep
    localparam int HOLD_EVERY   = 300;     // results between long receiver hold-offs
    localparam int HOLD_CYCLES  = 150;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                req_valid;
    logic                req_stall;
    logic                req_cmd;
    logic [SAMPLE_W-1:0] req_red;
    logic [SAMPLE_W-1:0] req_green;
    logic [SAMPLE_W-1:0] req_blue;
    logic [IDX_W-1:0]    req_index;
    logic [TBL_W-1:0]    req_value;
    logic                res_valid;
    logic                res_stall;
    logic [OUT_W-1:0]    res_red;
    logic [OUT_W-1:0]    res_green;
    logic [OUT_W-1:0]    res_blue;
    int                  mismatches;
    int                  pending;
    int                  cycles = 0;
    bit                  tx_burst = 1'b0;

    always #5 clk = ~clk;

    rgb_gamma_lut_interpolator_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (req_valid),
        .o_stall       (req_stall),
        .i_cmd         (req_cmd),
        .i_red_in      (req_red),
        .i_green_in    (req_green),
        .i_blue_in     (req_blue),
        .i_entry_index (req_index),
        .i_entry_value (req_value),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_red_out     (res_red),
        .o_green_out   (res_green),
        .o_blue_out    (res_blue)
    );

    rgb_gamma_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req_valid   (req_valid),
        .i_req_stall   (req_stall),
        .i_req_cmd     (req_cmd),
        .i_red_in      (req_red),
        .i_green_in    (req_green),
        .i_blue_in     (req_blue),
        .i_entry_index (req_index),
        .i_entry_value (req_value),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_red_out     (res_red),
        .i_green_out   (res_green),
        .i_blue_out    (res_blue),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Offer one request. Entered and left right at a clock edge: on return the
    // request was accepted at the current edge, so the next call may keep valid
    // high in this same step without a drop in between.
    task automatic send_req(input t_req_cmd cmd, input logic [SAMPLE_W-1:0] red,
                            input logic [SAMPLE_W-1:0] green,
                            input logic [SAMPLE_W-1:0] blue,
                            input logic [IDX_W-1:0] index, input logic [TBL_W-1:0] value);
        int gap;
        // an idle gap drawn by $urandom_range; bursts of back-to-back requests now and then
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_red   <= red;
        req_green <= green;
        req_blue  <= blue;
        req_index <= index;
        req_value <= value;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // unused fields of each request still carry random bits
    task automatic send_pixel(input logic [SAMPLE_W-1:0] red,
                              input logic [SAMPLE_W-1:0] green,
                              input logic [SAMPLE_W-1:0] blue);
        send_req(CMD_PIXEL, red, green, blue, IDX_W'($urandom), TBL_W'($urandom));
    endtask

    task automatic send_entry(input logic [IDX_W-1:0] index, input logic [TBL_W-1:0] value);
        send_req(CMD_TABLE_WR, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                 SAMPLE_W'($urandom), index, value);
    endtask

    // Bypass is only written with the block idle.
    task automatic set_bypass(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stop offering, wait for every pending pixel code, then let the pipe settle.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Samples lean on the corners: zero, full scale, frac 0 and frac 63.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       pick_sample = '0;
            1:       pick_sample = '1;
            2:       pick_sample = {8'($urandom), 8'h00};
            3:       pick_sample = {8'($urandom), 6'h3F, 2'($urandom)};
            default: pick_sample = SAMPLE_W'($urandom);
        endcase
    endfunction

    // Random entry values make falling segments too; the rails come up often.
    function automatic logic [TBL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       pick_level = '0;
            1:       pick_level = TBL_W'(TBL_MAX);
            default: pick_level = TBL_W'($urandom);
        endcase
    endfunction

    // Request side.
    initial begin
        int counted;
        int pick;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        req_valid   <= 1'b0;
        req_cmd     <= CMD_PIXEL;
        req_red     <= '0;
        req_green   <= '0;
        req_blue    <= '0;
        req_index   <= '0;
        req_value   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_bypass(1'b0);

        // The table has no reset: fill all 257 entries with a gamma-like
        // curve before any pixel goes in.
        for (int i = 0; i < TABLE_ENTRIES_DFLT; i++)
            send_entry(IDX_W'(i), TBL_W'($rtoi($sqrt(i / 256.0) * TBL_MAX)));

        // Directed, gamma path: rails, frac edges, top segment.
        send_pixel(16'h0000, 16'hFFFF, 16'h8000);
        send_pixel(16'h00FC, 16'h0004, 16'h0080);
        send_pixel(16'hFF00, 16'hFFFC, 16'h7F80);
        // falling segment 10: negative step is floored
        send_entry(9'd10, 14'h3FFF);
        send_entry(9'd11, 14'h0000);
        send_pixel(16'h0A84, 16'h0A04, 16'h0AFC);
        // steep rising segment 10
        send_entry(9'd11, 14'h3FFF);
        send_entry(9'd10, 14'h0000);
        send_pixel(16'h0A84, 16'h0A04, 16'h0AFC);
        // last entry at both rails; the top segment reads entry 256
        send_entry(9'd256, 14'h0000);
        send_pixel(16'hFFFC, 16'hFFC0, 16'hFF80);
        send_entry(9'd256, 14'h3FFF);
        send_pixel(16'hFFFF, 16'hFFC0, 16'hFF40);
        // writes past the table end are dropped; entry 255, the odd-bank alias
        // of 511, and entry 44 must keep their values
        send_entry(9'd300, 14'h0000);
        send_entry(9'd511, 14'h0000);
        send_pixel(16'h2C80, 16'h2BFC, 16'hFF40);

        // Directed, bypass path.
        wait_drained();
        set_bypass(1'b1);
        send_pixel(16'h0000, 16'hFFFF, 16'h003F);
        send_pixel(16'h0040, 16'hFFC0, 16'h5A5A);
        send_pixel(16'hA5A5, 16'h8000, 16'h7FFF);

        // Random phases, bypass alternating 0/1 starting with the gamma path.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_bypass(p[0]);
            counted = 0;
            while (counted < PHASE_REQS) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) begin
                    send_pixel(pick_sample(), pick_sample(), pick_sample());
                    counted++;
                end else if (pick < 19) begin
                    send_entry(IDX_W'($urandom_range(0, TABLE_ENTRIES_DFLT - 1)), pick_level());
                    counted++;
                end else begin
                    // out of range, ignored by the block
                    send_entry(IDX_W'($urandom_range(TABLE_ENTRIES_DFLT, 511)), pick_level());
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("rgb_gamma_lut_interpolator_top_tb: done, clean");
        end else begin
            $display("rgb_gamma_lut_interpolator_top_tb: done, errors");
        end
        $finish;
    end

    // Result side: a random stall after each result, with bursts of none, and
    // a long hold-off every few hundred results so the pipe fills and o_stall
    // pushes back on the request side.
    initial begin
        int rx_wait;
        int long_hold;
        int taken;
        bit rx_burst;
        rx_wait   = 0;
        long_hold = 0;
        taken     = 0;
        rx_burst  = 1'b0;
        res_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_valid && !res_stall) begin
                taken++;
                if (taken % HOLD_EVERY == 0) long_hold = HOLD_CYCLES;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
            end
            if (long_hold > 0) begin
                long_hold--;
                res_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rgb_gamma_lut_interpolator_top_tb: done, errors");
            $finish;
        end
    end

endmodule

[filelist.f]
+incdir+sv
sv/rgbg_pkg.sv
sv/rgbg_bank.sv
sv/rgbg_interp.sv
sv/rgb_gamma_lut_interpolator_top.sv
tb/sv/rgbg_tb_pkg.sv
tb/sv/rgb_gamma_checker.sv
tb/sv/rgb_gamma_lut_interpolator_top_tb.sv
